### design/utc_pkg.sv
// Shared types, constants and arithmetic helpers of the unicycle tracking controller.
`timescale 1ns / 1ps
package utc_pkg;

    // Fixed-point format and CORDIC length
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_ITERS = 24;
    localparam int ANG_FRAC     = 29;
    localparam int ANG_SH       = ANG_FRAC - FRAC_BITS;

    // Angle path widths: signed angle in, magnitude after scaling to Q29
    localparam int ANG_IN_W  = 36;
    localparam int MAG_W     = ANG_IN_W - 1 + ANG_SH;
    localparam int RED_STEPS = MAG_W - 31;
    localparam int RW        = 34;
    localparam int CW        = 32;
    localparam int QW        = 32;
    localparam int TRIG_LAT  = RED_STEPS + CORDIC_ITERS + 3;

    // Divider widths and latency
    localparam int QB       = 32;
    localparam int DEN_W    = 34;
    localparam int NUM_W    = DEN_W + QB;
    localparam int DIV_LAT  = QB + 2;
    localparam int POST_LAT = 5;
    localparam int PIPE_LAT = TRIG_LAT + POST_LAT + DIV_LAT;

    // Angle constants in Q29
    localparam logic signed [RW-1:0] TWO_PI_A    = 34'sd3373259426;
    localparam logic signed [RW-1:0] PI_A        = 34'sd1686629713;
    localparam logic signed [RW-1:0] HALF_PI_A   = 34'sd843314857;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sd326016437;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    // Register indexes and reset values
    localparam logic [1:0]  REG_ACCEL_GAIN  = 2'd0;
    localparam logic [1:0]  REG_REF_AMP     = 2'd1;
    localparam logic [1:0]  REG_Y_FREQ_MULT = 2'd2;
    localparam logic [30:0] GAIN_RESET      = 31'd6553600;
    localparam logic [30:0] AMP_RESET       = 31'd655360;
    localparam logic [3:0]  KMUL_RESET      = 4'd3;

    typedef struct packed {
        logic [30:0]        time_now;
        logic signed [31:0] est_x;
        logic signed [31:0] est_y;
        logic signed [31:0] speed;
        logic signed [31:0] heading;
    } t_in;

    typedef struct packed {
        logic signed [31:0] turn_rate;
        logic signed [31:0] accel_cmd;
        logic               singular;
    } t_out;

    typedef struct packed {
        logic signed [31:0] est_x;
        logic signed [31:0] est_y;
        logic signed [31:0] speed;
    } t_side;

    typedef struct packed {
        logic neg;
        logic num_pos;
        logic num_neg;
        logic zero;
        logic ovf;
    } t_divflag;

    // Arctangent of 2^-i in Q29.
    function automatic logic signed [RW-1:0] atan_entry(input int i);
        logic signed [RW-1:0] v;
        v = '0;
        case (i)
            0: v = 34'sd421657428;
            1: v = 34'sd248918915;
            2: v = 34'sd131521918;
            3: v = 34'sd66762579;
            4: v = 34'sd33510843;
            5: v = 34'sd16771758;
            6: v = 34'sd8387925;
            7: v = 34'sd4194219;
            8: v = 34'sd2097141;
            9: v = 34'sd1048575;
            default: begin
                if (i < 30) v[29-i] = 1'b1;
            end
        endcase
        return v;
    endfunction

    // Rounded fixed-point product, floor after adding half an LSB.
    function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                                input logic signed [31:0] b);
        logic signed [65:0] p;
        p = a * b;
        p = p + (66'sd1 <<< (FRAC_BITS - 1));
        p = p >>> FRAC_BITS;
        return p[33:0];
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh07FFFFFFF)      r = S32_MAX;
        else if (v < -34'sh80000000) r = S32_MIN;
        else                         r = v[31:0];
        return r;
    endfunction

endpackage

### design/utc_trig.sv
// Pipelined angle reduction modulo two pi followed by a rotation-mode CORDIC.
`timescale 1ns / 1ps
module utc_trig import utc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [ANG_IN_W-1:0] i_ang,
    output logic signed [QW-1:0]       o_cos,
    output logic signed [QW-1:0]       o_sin
);

    localparam logic [MAG_W:0] M_EXT = (MAG_W + 1)'(TWO_PI_A);

    logic [ANG_IN_W-1:0]  n_abs;
    logic [MAG_W-1:0]     r_rem [0:RED_STEPS];
    logic                 r_neg [0:RED_STEPS];
    logic signed [RW-1:0] n_fold;
    logic                 n_flip;
    logic signed [RW-1:0] r_z [0:CORDIC_ITERS];
    logic signed [CW-1:0] r_x [0:CORDIC_ITERS];
    logic signed [CW-1:0] r_y [0:CORDIC_ITERS];
    logic                 r_flip [0:CORDIC_ITERS];
    logic signed [CW-1:0] n_xf;
    logic signed [CW-1:0] n_yf;

    // Magnitude of the angle, scaled to Q29.
    assign n_abs = i_ang[ANG_IN_W-1] ? ANG_IN_W'(-i_ang) : ANG_IN_W'(i_ang);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {n_abs[ANG_IN_W-2:0], ANG_SH'(0)};
            r_neg[0] <= i_ang[ANG_IN_W-1];
        end
    end

    // One conditional subtraction of a shifted modulus per stage.
    for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
        localparam logic [MAG_W:0] SUB = M_EXT << (RED_STEPS - 1 - j);
        logic [MAG_W:0] n_ext;
        assign n_ext = {1'b0, r_rem[j]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= (n_ext >= SUB) ? MAG_W'(n_ext - SUB) : r_rem[j];
                r_neg[j+1] <= r_neg[j];
            end
        end
    end

    // Floor remainder for negative angles, then fold into the right half plane.
    always_comb begin
        n_fold = RW'(r_rem[RED_STEPS]);
        n_flip = 1'b0;
        if (r_neg[RED_STEPS] && n_fold != '0) n_fold = TWO_PI_A - n_fold;
        if (n_fold > PI_A) n_fold = n_fold - TWO_PI_A;
        if (n_fold > HALF_PI_A) begin
            n_fold = n_fold - PI_A;
            n_flip = 1'b1;
        end else if (n_fold < -HALF_PI_A) begin
            n_fold = n_fold + PI_A;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0]    <= n_fold;
            r_x[0]    <= CORDIC_GAIN;
            r_y[0]    <= '0;
            r_flip[0] <= n_flip;
        end
    end

    // CORDIC rotations, one per stage.
    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_rot
        localparam logic signed [RW-1:0] ATAN = atan_entry(i);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][RW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATAN;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATAN;
                end
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    // Undo the fold and round back to the working fraction.
    assign n_xf = r_flip[CORDIC_ITERS] ? -r_x[CORDIC_ITERS] : r_x[CORDIC_ITERS];
    assign n_yf = r_flip[CORDIC_ITERS] ? -r_y[CORDIC_ITERS] : r_y[CORDIC_ITERS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= QW'((n_xf + (CW'(1) <<< (ANG_SH - 1))) >>> ANG_SH);
            o_sin <= QW'((n_yf + (CW'(1) <<< (ANG_SH - 1))) >>> ANG_SH);
        end
    end

endmodule

### design/utc_div.sv
// Pipelined restoring divider, truncating toward zero, with saturation.
`timescale 1ns / 1ps
module utc_div import utc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output logic signed [31:0]      o_q,
    output logic                    o_zero
);

    logic [NUM_W-1:0]   n_mnum;
    logic [DEN_W-1:0]   n_mden;
    logic [NUM_W:0]     r_rem [0:QB];
    logic [DEN_W-1:0]   r_den [0:QB];
    logic [QB-1:0]      r_q   [0:QB];
    t_divflag           r_flag [0:QB];
    logic signed [31:0] n_q;

    assign n_mnum = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign n_mden = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);

    // Magnitudes, signs and the overflow check.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]          <= {1'b0, n_mnum};
            r_den[0]          <= n_mden;
            r_q[0]            <= '0;
            r_flag[0].neg     <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_flag[0].num_pos <= !i_num[NUM_W-1] && (i_num != '0);
            r_flag[0].num_neg <= i_num[NUM_W-1];
            r_flag[0].zero    <= (i_den == '0);
            r_flag[0].ovf     <= {1'b0, n_mnum} >= {1'b0, n_mden, QB'(0)};
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < QB; j++) begin : g_step
        logic [NUM_W:0] n_sub;
        assign n_sub = (NUM_W + 1)'(r_den[j]) << (QB - 1 - j);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[j] >= n_sub) begin
                    r_rem[j+1] <= r_rem[j] - n_sub;
                    r_q[j+1]   <= r_q[j] | (QB'(1) << (QB - 1 - j));
                end else begin
                    r_rem[j+1] <= r_rem[j];
                    r_q[j+1]   <= r_q[j];
                end
                r_den[j+1]  <= r_den[j];
                r_flag[j+1] <= r_flag[j];
            end
        end
    end

    // Sign, saturation and the zero-divisor case.
    always_comb begin
        if (r_flag[QB].zero) begin
            if (r_flag[QB].num_pos)      n_q = S32_MAX;
            else if (r_flag[QB].num_neg) n_q = S32_MIN;
            else                         n_q = '0;
        end else if (r_flag[QB].ovf) begin
            n_q = r_flag[QB].neg ? S32_MIN : S32_MAX;
        end else if (r_flag[QB].neg) begin
            n_q = (r_q[QB] > 32'h80000000) ? S32_MIN : -$signed(r_q[QB]);
        end else begin
            n_q = (r_q[QB] > 32'h7FFFFFFF) ? S32_MAX : $signed(r_q[QB]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q    <= n_q;
            o_zero <= r_flag[QB].zero;
        end
    end

endmodule

### design/unicycle_tracking_controller_top.sv
// Top level of the unicycle tracking controller: trig units, control law and dividers.
//
//  Channel  Direction  Handshake               Word
//  input    in         i_in_valid/o_in_stall   t_in: time, position, speed, heading
//  output   out        o_out_valid/i_out_stall t_out: turn rate, acceleration, singular
//  config   in         i_cfg_valid/o_cfg_ready index and 32-bit data
//
// One word enters per cycle unless o_in_stall is high; each result passes through the
// trig stages (17 reduction, 24 CORDIC and 3 more), 5 control-law stages and a
// 34-stage divider. The pipeline advances as one unit; it holds only while a result
// waits at the output under stall. Reset is synchronous and clears the valid bits
// and the configuration registers to their defaults.
`timescale 1ns / 1ps
module unicycle_tracking_controller_top import utc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [30:0]         r_gain;
    logic [30:0]         r_amp;
    logic [3:0]          r_k;
    logic [PIPE_LAT-1:0] r_vld;
    logic                w_en;
    logic [34:0]         w_kt;
    t_side               r_side [0:TRIG_LAT-1];
    logic signed [QW-1:0] w_ct, w_st, w_ck, w_sk, w_ch, w_sh;
    logic signed [33:0]  w_amp;

    logic signed [33:0] r_p1_wx, r_p1_wy, r_p1_mst, r_p1_mck;
    logic signed [31:0] r_p1_vc, r_p1_vs, r_p1_ch, r_p1_sh, r_p1_px, r_p1_py;
    logic signed [35:0] r_p2_ex, r_p2_eyp;
    logic signed [38:0] r_p2_dwy;
    logic signed [32:0] r_p2_a11;
    logic signed [33:0] r_p2_m1, r_p2_m2;
    logic signed [31:0] r_p2_vc, r_p2_ch, r_p2_sh;
    logic signed [39:0] n_ey;
    logic               r_p3_sx, r_p3_sy;
    logic signed [33:0] r_p3_det;
    logic signed [32:0] r_p3_a11;
    logic signed [31:0] r_p3_vc, r_p3_ch, r_p3_sh;
    logic signed [33:0] r_p4_n1, r_p4_n2, r_p4_det;
    logic signed [NUM_W-1:0] r_p5_num1, r_p5_num2;
    logic signed [DEN_W-1:0] r_p5_det;
    logic signed [31:0] w_u1, w_u2;
    logic               w_z1, w_z2;

    // Configuration registers; the port never waits.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_amp  <= AMP_RESET;
            r_k    <= KMUL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ACCEL_GAIN:  r_gain <= i_cfg_data[30:0];
                REG_REF_AMP:     r_amp  <= i_cfg_data[30:0];
                REG_Y_FREQ_MULT: r_k    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance and valid bits.
    assign w_en        = !r_vld[PIPE_LAT-1] || !i_out_stall;
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    // Three trig units: t, k*t and the heading.
    assign w_kt = 35'(r_k) * 35'(i_in_data.time_now);

    utc_trig u_trig_t (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang ($signed({5'b0, i_in_data.time_now})),
        .o_cos (w_ct),
        .o_sin (w_st)
    );

    utc_trig u_trig_kt (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang ($signed({1'b0, w_kt})),
        .o_cos (w_ck),
        .o_sin (w_sk)
    );

    utc_trig u_trig_h (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (ANG_IN_W'(i_in_data.heading)),
        .o_cos (w_ch),
        .o_sin (w_sh)
    );

    // Position and speed follow the trig latency.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= '{est_x: i_in_data.est_x, est_y: i_in_data.est_y,
                           speed: i_in_data.speed};
            for (int d = 1; d < TRIG_LAT; d++) r_side[d] <= r_side[d-1];
        end
    end

    // Stage one: reference and velocity products.
    assign w_amp = $signed({3'b0, r_amp});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_wx  <= mulq(w_amp, w_ct);
            r_p1_wy  <= mulq(w_amp, w_sk);
            r_p1_mst <= mulq(w_amp, w_st);
            r_p1_mck <= mulq(w_amp, w_ck);
            r_p1_vc  <= sat32(mulq(34'(r_side[TRIG_LAT-1].speed), w_ch));
            r_p1_vs  <= sat32(mulq(34'(r_side[TRIG_LAT-1].speed), w_sh));
            r_p1_ch  <= w_ch;
            r_p1_sh  <= w_sh;
            r_p1_px  <= r_side[TRIG_LAT-1].est_x;
            r_p1_py  <= r_side[TRIG_LAT-1].est_y;
        end
    end

    // Stage two: x error, partial y error, determinant products.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_ex  <= 36'(r_p1_wx) - 36'(r_p1_px) - 36'(r_p1_mst) - 36'(r_p1_vc);
            r_p2_eyp <= 36'(r_p1_wy) - 36'(r_p1_py) - 36'(r_p1_vs);
            r_p2_dwy <= 39'($signed({1'b0, r_k})) * 39'(r_p1_mck);
            r_p2_a11 <= -33'(r_p1_vs);
            r_p2_m1  <= mulq(-34'(r_p1_vs), r_p1_sh);
            r_p2_m2  <= mulq(34'(r_p1_ch), r_p1_vc);
            r_p2_vc  <= r_p1_vc;
            r_p2_ch  <= r_p1_ch;
            r_p2_sh  <= r_p1_sh;
        end
    end

    // Stage three: bang-bang signs and the determinant. Zero error counts as negative.
    assign n_ey = 40'(r_p2_eyp) + 40'(r_p2_dwy);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p3_sx  <= r_p2_ex > 0;
            r_p3_sy  <= n_ey > 0;
            r_p3_det <= r_p2_m1 - r_p2_m2;
            r_p3_a11 <= r_p2_a11;
            r_p3_vc  <= r_p2_vc;
            r_p3_ch  <= r_p2_ch;
            r_p3_sh  <= r_p2_sh;
        end
    end

    // Stage four: numerators with the signs factored out.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p4_n1  <= (r_p3_sx ? 34'(r_p3_sh) : -34'(r_p3_sh))
                      - (r_p3_sy ? 34'(r_p3_ch) : -34'(r_p3_ch));
            r_p4_n2  <= (r_p3_sx ? -34'(r_p3_vc) : 34'(r_p3_vc))
                      + (r_p3_sy ? 34'(r_p3_a11) : -34'(r_p3_a11));
            r_p4_det <= r_p3_det;
        end
    end

    // Stage five: scale by the gain.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p5_num1 <= NUM_W'($signed({1'b0, r_gain})) * NUM_W'(r_p4_n1);
            r_p5_num2 <= NUM_W'($signed({1'b0, r_gain})) * NUM_W'(r_p4_n2);
            r_p5_det  <= DEN_W'(r_p4_det);
        end
    end

    // Division by the determinant.
    utc_div u_div_u1 (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_p5_num1),
        .i_den  (r_p5_det),
        .o_q    (w_u1),
        .o_zero (w_z1)
    );

    utc_div u_div_u2 (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_p5_num2),
        .i_den  (r_p5_det),
        .o_q    (w_u2),
        .o_zero (w_z2)
    );

    assign o_out_data = '{turn_rate: w_u1, accel_cmd: w_u2, singular: w_z1 | w_z2};

`ifndef SYNTHESIS
    // A singular result carries only saturated or zero commands.
    a_sing_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.singular |->
            (o_out_data.turn_rate == S32_MAX || o_out_data.turn_rate == S32_MIN ||
             o_out_data.turn_rate == 32'sd0) &&
            (o_out_data.accel_cmd == S32_MAX || o_out_data.accel_cmd == S32_MIN ||
             o_out_data.accel_cmd == 32'sd0))
        else $error("singular result with unsaturated command");

    // Reset leaves the pipeline empty.
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    // Reset restores the default register values.
    a_rst_cfg: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> r_gain == GAIN_RESET && r_amp == AMP_RESET &&
                            r_k == KMUL_RESET)
        else $error("configuration not at defaults after reset");
`endif

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench of the unicycle tracking controller top level.
`timescale 1ns / 1ps
module tb_top;
    import utc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    unicycle_tracking_controller_top DUT (.*);

    typedef struct {
        t_in  word;
        bit   typed;
        t_out want;
    } dir_row_t;

    // Shadow copy of the configuration registers.
    longint gain_q, amp_q, kmul_q;
    t_out   pending_cmds[$];
    int     fail_count = 0;
    int     n_sent = 0, n_checked = 0, n_singular = 0;
    bit     quiet = 0;
    int     stall_len = 0;
    dir_row_t dir_rows[$];

    // Clock.
    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint sat_s32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint arctan_q29(input int i);
        longint tab[10] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                            16771758, 8387925, 4194219, 2097141, 1048575};
        if (i < 10) return tab[i];
        if (i < 30) return 64'sd1 <<< (29 - i);
        return 0;
    endfunction

    // Cosine and sine of an angle in Q16 by range reduction and rotation CORDIC.
    task automatic cordic_cos_sin(input longint ang, output longint c, output longint s);
        longint r, x, y, nx, two_pi, pi_a, half_pi;
        bit     neg;
        two_pi  = longint'(TWO_PI_A);
        pi_a    = longint'(PI_A);
        half_pi = longint'(HALF_PI_A);
        r   = (ang * (64'sd1 <<< ANG_SH)) % two_pi;
        x   = longint'(CORDIC_GAIN);
        y   = 0;
        neg = 0;
        if (r < 0) r += two_pi;
        if (r > pi_a) r -= two_pi;
        if (r > half_pi) begin
            r -= pi_a;
            neg = 1;
        end else if (r < -half_pi) begin
            r += pi_a;
            neg = 1;
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            if (r >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                r -= arctan_q29(i);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                r += arctan_q29(i);
            end
            x = nx;
        end
        if (neg) begin
            x = -x;
            y = -y;
        end
        c = (x + (64'sd1 <<< (ANG_SH - 1))) >>> ANG_SH;
        s = (y + (64'sd1 <<< (ANG_SH - 1))) >>> ANG_SH;
    endtask

    function automatic longint saturating_div(input longint num, input longint den,
                                              inout bit sing);
        if (den == 0) begin
            sing = 1;
            if (num > 0) return 64'sd2147483647;
            if (num < 0) return -64'sd2147483648;
            return 0;
        end
        return sat_s32(num / den);
    endfunction

    // Control law for one word under the current register settings.
    task automatic predict_command(input t_in w, output t_out r);
        longint t, px, py, v, hd, ct, st, ck, sk, ch, sh;
        longint wx, wy, dwx, dwy, vc, vs, ex, ey, sx, sy;
        longint a11, a12, a21, a22, det, n1, n2, u1, u2;
        bit sing;
        t  = longint'(w.time_now);
        px = longint'(w.est_x);
        py = longint'(w.est_y);
        v  = longint'(w.speed);
        hd = longint'(w.heading);
        sing = 0;
        cordic_cos_sin(t, ct, st);
        cordic_cos_sin(kmul_q * t, ck, sk);
        cordic_cos_sin(hd, ch, sh);
        wx  = qmul(amp_q, ct);
        wy  = qmul(amp_q, sk);
        dwx = -qmul(amp_q, st);
        dwy = kmul_q * qmul(amp_q, ck);
        vc  = sat_s32(qmul(v, ch));
        vs  = sat_s32(qmul(v, sh));
        ex  = wx - px + dwx - vc;
        ey  = wy - py + dwy - vs;
        sx  = (ex > 0) ? 1 : -1;
        sy  = (ey > 0) ? 1 : -1;
        a11 = -vs;
        a12 = ch;
        a21 = vc;
        a22 = sh;
        det = qmul(a11, a22) - qmul(a12, a21);
        n1  = sx * a22 - sy * a12;
        n2  = -sx * a21 + sy * a11;
        u1  = saturating_div(gain_q * n1, det, sing);
        u2  = saturating_div(gain_q * n2, det, sing);
        r.turn_rate = u1[31:0];
        r.accel_cmd = u2[31:0];
        r.singular  = sing;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        $display("mismatch on %s at result %0d: got %0h, expected %0h",
                 what, n_checked, got, want);
    endtask

    // Output checker: each accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        t_out w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cmds.size() == 0) begin
                report_mismatch("unexpected word", longint'(o_out_data.turn_rate), 0);
            end else begin
                w = pending_cmds.pop_front();
                if (o_out_data.turn_rate !== w.turn_rate)
                    report_mismatch("turn_rate", o_out_data.turn_rate, w.turn_rate);
                if (o_out_data.accel_cmd !== w.accel_cmd)
                    report_mismatch("accel_cmd", o_out_data.accel_cmd, w.accel_cmd);
                if (o_out_data.singular !== w.singular)
                    report_mismatch("singular", o_out_data.singular, w.singular);
                if (w.singular) n_singular++;
            end
            n_checked++;
        end
    end

    // Output stall in random bursts; none once the quiet tail starts.
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
            stall_len   <= 0;
        end else if (stall_len > 0) begin
            stall_len <= stall_len - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 2) == 0);
            stall_len   <= $urandom_range(1, 15);
        end
    end

    // Register write, held until the port takes it; then the port idles and the shadow copy is updated.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_ACCEL_GAIN:  gain_q = longint'(data[30:0]);
            REG_REF_AMP:     amp_q  = longint'(data[30:0]);
            REG_Y_FREQ_MULT: kmul_q = longint'(data[3:0]);
            default: ;
        endcase
    endtask

    // Present one word, optionally after an idle burst, and log its expectation.
    task automatic send_word(input t_in w, input bit typed, input t_out want);
        t_out r;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (typed) r = want;
        else predict_command(w, r);
        pending_cmds.push_back(r);
        n_sent++;
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_in random_word;
        t_in w;
        w = {31'($urandom), $urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 3))
            0: ;
            default: begin
                // Plausible robot state near the reference.
                w.time_now = 31'($urandom_range(0, 32'h0064_0000));
                w.est_x    = $signed($urandom_range(0, 32'h0028_0000)) - 32'sh0014_0000;
                w.est_y    = $signed($urandom_range(0, 32'h0028_0000)) - 32'sh0014_0000;
                w.speed    = ($urandom_range(0, 5) == 0) ? 32'sd0
                           : $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
                w.heading  = $signed($urandom_range(0, 32'h000E_0000)) - 32'sh0007_0000;
            end
        endcase
        return w;
    endfunction

    initial begin
        t_out none, z_want;
        t_in  w;
        i_rst_n     = 0;
        i_in_valid  = 0;
        i_in_data   = '0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_out_stall = 0;
        gain_q = longint'(GAIN_RESET);
        amp_q  = longint'(AMP_RESET);
        kmul_q = longint'(KMUL_RESET);
        none   = '0;
        // All-zero word: no speed, so the determinant vanishes and u1 saturates low.
        z_want = '{turn_rate: S32_MIN, accel_cmd: 32'sd0, singular: 1'b1};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at reset settings.
        dir_rows.push_back('{'0, 1, z_want});
        dir_rows.push_back('{'{31'h7FFFFFFF, S32_MAX, S32_MAX, S32_MAX, S32_MAX}, 0, none});
        dir_rows.push_back('{'{31'h0, S32_MIN, S32_MIN, S32_MIN, S32_MIN}, 0, none});
        dir_rows.push_back('{'{31'h0, S32_MAX, S32_MIN, S32_MIN, S32_MAX}, 0, none});
        dir_rows.push_back('{'{31'h7FFFFFFF, S32_MIN, S32_MAX, S32_MAX, S32_MIN}, 0, none});
        dir_rows.push_back('{'{31'h1921F, 0, 0, 32'sh10000, 32'sh1921F}, 0, none});
        dir_rows.push_back('{'{31'h3243F, 32'sh10000, 0, 32'sh20000, 32'sh3243F}, 0, none});
        dir_rows.push_back('{'{31'h10000, 0, 0, 32'sh10000, -32'sh1921F}, 0, none});
        dir_rows.push_back('{'{31'h10000, 0, 0, 32'sh7FFF0000, 32'sh1921F}, 0, none});
        dir_rows.push_back('{'{31'h10000, 0, 0, 32'sh80000000, 32'sh0}, 0, none});
        dir_rows.push_back('{'{31'h12345, 32'sh5, -32'sh5, 32'sh0, 32'sh6487F}, 0, none});
        dir_rows.push_back('{'{31'h5, 32'sh0A0000, 32'sh1E0000, 32'sh1, 32'sh1}, 0, none});
        foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
        drain();

        // Extreme settings, dropped upper bits and an unknown index.
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_ACCEL_GAIN, 32'h7FFFFFFF);
                    write_reg(REG_REF_AMP, 32'h7FFFFFFF);
                    write_reg(REG_Y_FREQ_MULT, 32'd15);
                end
                1: begin
                    write_reg(REG_ACCEL_GAIN, 32'd0);
                    write_reg(REG_REF_AMP, 32'd0);
                    write_reg(REG_Y_FREQ_MULT, 32'd0);
                end
                2: begin
                    write_reg(REG_ACCEL_GAIN, 32'hFFFFFFFF);
                    write_reg(REG_REF_AMP, 32'hFFFFFFFF);
                    write_reg(REG_Y_FREQ_MULT, 32'hFFFFFFF1);
                    write_reg(2'd3, $urandom);
                end
                default: begin
                    write_reg(REG_ACCEL_GAIN, $urandom_range(0, 32'h00FF_0000));
                    write_reg(REG_REF_AMP, $urandom_range(0, 32'h0020_0000));
                    write_reg(REG_Y_FREQ_MULT, $urandom_range(0, 15));
                    if ($urandom_range(0, 1)) write_reg(2'd3, $urandom);
                end
            endcase
            if (ph == 6) quiet = 1;
            repeat (240) begin
                w = random_word();
                send_word(w, 0, none);
            end
            drain();
        end

        repeat (PIPE_LAT + 20) @(posedge i_clk);
        $display("Sent %0d words over eight register settings; %0d results checked, %0d singular.",
                 n_sent, n_checked, n_singular);
        if (fail_count == 0 && pending_cmds.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
